// File: rtl/core/retransmit_frame_queue_bank_assert.svh
// Assertion macros for the retransmit frame queue bank.
// RFQ_ASSERT checks a property at every rising clock edge outside reset.
// RFQ_ASSERT_NEVER checks that a condition never holds outside reset.
`ifndef RETRANSMIT_FRAME_QUEUE_BANK_ASSERT_SVH
`define RETRANSMIT_FRAME_QUEUE_BANK_ASSERT_SVH

`ifndef SYNTHESIS

`define RFQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rfq assertion failed");

`define RFQ_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rfq forbidden condition seen");

`else

`define RFQ_ASSERT(label, clk, rst_n, prop)

`define RFQ_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: rtl/core/rfq_pkg.sv
`default_nettype none

package rfq_pkg;

    // queue bank layout
    localparam int NUM_QUEUES = 5;
    localparam logic [7:0] CRYPTO_TYPE = 8'h06;

    // stream widths
    localparam int IN_W        = 60;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_W       = 35;
    localparam int OUT_TDATA_W = 40;

    typedef logic [2:0] qidx_t;

    localparam qidx_t Q_INIT        = 3'd0;
    localparam qidx_t Q_INIT_CRYPTO = 3'd1;
    localparam qidx_t Q_HS          = 3'd2;
    localparam qidx_t Q_HS_CRYPTO   = 3'd3;
    localparam qidx_t Q_APP         = 3'd4;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_GET  = 2'd1,
        OP_DROP = 2'd2,
        OP_RSVD = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        LVL_INIT = 2'd0,
        LVL_HS   = 2'd1,
        LVL_APP  = 2'd2,
        LVL_RSVD = 2'd3
    } level_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_LEVEL = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_RSVD      = 2'd3
    } status_t;

    // one stored queue entry: handle low, size high
    typedef struct packed {
        logic [15:0] bytes;
        logic [15:0] handle;
    } entry_t;

    // input item, first field in the highest bits
    typedef struct packed {
        logic [15:0] room;
        logic [15:0] frame_bytes;
        logic [7:0]  frame_type;
        logic [15:0] frame_handle;
        level_t      level;
        op_t         op;
    } in_item_t;

    // result item, first field in the highest bits
    typedef struct packed {
        status_t     status;
        logic [15:0] out_bytes;
        logic [15:0] out_handle;
        logic        got_frame;
    } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/rfq_entry_ram.sv
`default_nettype none

module rfq_entry_ram
    import rfq_pkg::*;
#(
    parameter int DEPTH = 80,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire entry_t            wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr_a,
    input  wire logic [ADDR_W-1:0] rd_addr_b,
    output entry_t                 rd_data_a,
    output entry_t                 rd_data_b
);

    entry_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // two registered read ports
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/retransmit_frame_queue_bank.sv
// Flow: the input item is registered at accept together with the entry memory read
// of the queue heads; the read-modify-write of pointers and counts follows in S_EXEC
// once the output register is free. No new item is accepted until S_EXEC is done.
// Reset: rst_n (async, active low) empties all five queues and clears the output valid.
// Entry memory contents are not cleared; no clearing pass, items accepted at once.
`default_nettype none

module retransmit_frame_queue_bank
    import rfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // op[1:0], level[3:2], frame_handle[19:4], frame_type[27:20],
    // frame_bytes[43:28], room[59:44], zero fill [63:60]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // got_frame[0], out_handle[16:1], out_bytes[32:17], status[34:33],
    // zero fill [39:35]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    in_item_t          in_item;
    in_item_t          item_reg;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [PTR_W-1:0]  head_reg [NUM_QUEUES];
    logic [PTR_W-1:0]  head_next [NUM_QUEUES];
    logic [PTR_W-1:0]  tail_reg [NUM_QUEUES];
    logic [PTR_W-1:0]  tail_next [NUM_QUEUES];
    logic [CNT_W-1:0]  cnt_reg [NUM_QUEUES];
    logic [CNT_W-1:0]  cnt_next [NUM_QUEUES];

    logic              accept;
    logic              exec_go;
    qidx_t             rd_qa, rd_qb;
    qidx_t             ex_qa, ex_qb, add_q;
    logic              fit_a, fit_b;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
    entry_t            rd_data_a, rd_data_b;
    logic              cnt_over;

    function automatic logic [ADDR_W-1:0] slot_addr(qidx_t q, logic [PTR_W-1:0] p);
        return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
    endfunction

    function automatic logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign in_item       = in_item_t'(s_axis_tdata[IN_W-1:0]);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign exec_go       = (state_reg == S_EXEC) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_reg};

    // head reads at accept: port A crypto or app head, port B plain head
    always_comb
    begin
        unique case (in_item.level)
            LVL_APP:  rd_qa = Q_APP;
            LVL_HS:   rd_qa = Q_HS_CRYPTO;
            default:  rd_qa = Q_INIT_CRYPTO;
        endcase
        rd_qb = (in_item.level == LVL_HS) ? Q_HS : Q_INIT;
    end

    assign rd_addr_a = slot_addr(rd_qa, head_reg[rd_qa]);
    assign rd_addr_b = slot_addr(rd_qb, head_reg[rd_qb]);

    rfq_entry_ram #(
        .DEPTH (RAM_DEPTH)
    ) u_entry_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // queue selection for the item in execution
    always_comb
    begin
        unique case (item_reg.level)
            LVL_APP:  ex_qa = Q_APP;
            LVL_HS:   ex_qa = Q_HS_CRYPTO;
            default:  ex_qa = Q_INIT_CRYPTO;
        endcase
        ex_qb = (item_reg.level == LVL_HS) ? Q_HS : Q_INIT;
        if (item_reg.level == LVL_APP)
        begin
            add_q = Q_APP;
        end
        else
        begin
            add_q = {1'b0, item_reg.level[0], (item_reg.frame_type == CRYPTO_TYPE)};
        end
    end

    // head fits: queue not empty and size within room
    assign fit_a = (cnt_reg[ex_qa] != '0) && (rd_data_a.bytes <= item_reg.room);
    assign fit_b = (cnt_reg[ex_qb] != '0) && (rd_data_b.bytes <= item_reg.room);

    // read-modify-write of pointers and counts; entry write on add
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        out_next  = out_reg;
        wr_en     = 1'b0;
        wr_addr   = slot_addr(add_q, tail_reg[add_q]);
        wr_data   = '{bytes: item_reg.frame_bytes, handle: item_reg.frame_handle};
        if (exec_go)
        begin
            out_next = '{status: STAT_OK, out_bytes: '0, out_handle: '0, got_frame: 1'b0};
            if (item_reg.op == OP_RSVD)
            begin
                out_next.status = STAT_OK;
            end
            else if (item_reg.level == LVL_RSVD)
            begin
                out_next.status = STAT_BAD_LEVEL;
            end
            else
            begin
                unique case (item_reg.op)
                    OP_ADD:
                    begin
                        if (cnt_reg[add_q] == CNT_W'(QUEUE_DEPTH))
                        begin
                            out_next.status = STAT_FULL;
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            tail_next[add_q] = next_slot(tail_reg[add_q]);
                            cnt_next[add_q]  = cnt_reg[add_q] + CNT_W'(1);
                        end
                    end
                    OP_GET:
                    begin
                        // crypto (or app) head first, plain head as fallback
                        if (fit_a)
                        begin
                            head_next[ex_qa]    = next_slot(head_reg[ex_qa]);
                            cnt_next[ex_qa]     = cnt_reg[ex_qa] - CNT_W'(1);
                            out_next.got_frame  = 1'b1;
                            out_next.out_handle = rd_data_a.handle;
                            out_next.out_bytes  = rd_data_a.bytes;
                        end
                        else if (fit_b && (item_reg.level != LVL_APP))
                        begin
                            head_next[ex_qb]    = next_slot(head_reg[ex_qb]);
                            cnt_next[ex_qb]     = cnt_reg[ex_qb] - CNT_W'(1);
                            out_next.got_frame  = 1'b1;
                            out_next.out_handle = rd_data_b.handle;
                            out_next.out_bytes  = rd_data_b.bytes;
                        end
                    end
                    OP_DROP:
                    begin
                        if (item_reg.level == LVL_APP)
                        begin
                            out_next.status = STAT_BAD_LEVEL;
                        end
                        else
                        begin
                            head_next[ex_qa] = '0;
                            tail_next[ex_qa] = '0;
                            cnt_next[ex_qa]  = '0;
                            head_next[ex_qb] = '0;
                            tail_next[ex_qb] = '0;
                            cnt_next[ex_qb]  = '0;
                        end
                    end
                    default:
                    begin
                        out_next.status = STAT_OK;
                    end
                endcase
            end
        end
    end

    // sequencer: accept, then execute once the output register is free
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        if (exec_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
        out_reg <= out_next;
    end

    // any queue count above the depth
    always_comb
    begin
        cnt_over = 1'b0;
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            if (cnt_reg[i] > CNT_W'(QUEUE_DEPTH))
            begin
                cnt_over = 1'b1;
            end
        end
    end

`include "retransmit_frame_queue_bank_assert.svh"

    `RFQ_ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_over)
    `RFQ_ASSERT(a_accept_exec, clk, rst_n, accept |=> (state_reg == S_EXEC))
    `RFQ_ASSERT(a_write_in_exec, clk, rst_n, wr_en |-> exec_go && (item_reg.op == OP_ADD))
    `RFQ_ASSERT(a_got_ok, clk, rst_n, (m_axis_tvalid && out_reg.got_frame) |-> (out_reg.status == STAT_OK))

endmodule

`default_nettype wire

// File: verif/tb_retransmit_frame_queue_bank.sv
`default_nettype none

module tb_retransmit_frame_queue_bank;
    import rfq_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int ITEM_TARGET   = 550;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;

    // Scoreboard: mirrors the queue bank and holds the results still owed
    class frame_queue_scoreboard #(int DEPTH = 16);
        entry_t    slots [NUM_QUEUES][DEPTH];
        int        head [NUM_QUEUES];
        int        tail [NUM_QUEUES];
        int        fill [NUM_QUEUES];
        out_item_t owed_results [$];
        int        errors;

        function new();
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                head[q] = 0;
                tail[q] = 0;
                fill[q] = 0;
            end
            errors = 0;
        endfunction

        function void empty_queue(int q);
            head[q] = 0;
            tail[q] = 0;
            fill[q] = 0;
        endfunction

        // pop the head of queue q if it is occupied and fits the room limit
        function bit pop_fitting(int q, logic [15:0] room, inout out_item_t res);
            entry_t e;
            if (fill[q] == 0)
                return 1'b0;
            e = slots[q][head[q]];
            if (e.bytes > room)
                return 1'b0;
            head[q] = (head[q] + 1 >= DEPTH) ? 0 : head[q] + 1;
            fill[q]--;
            res.got_frame  = 1'b1;
            res.out_handle = e.handle;
            res.out_bytes  = e.bytes;
            return 1'b1;
        endfunction

        // work out the result of one accepted input item
        function void note_accepted(in_item_t it);
            out_item_t res;
            int        q;
            res = '0;
            res.status = STAT_OK;
            if (it.op == OP_RSVD)
            begin
                // reserved op: nothing happens
            end
            else if (it.level == LVL_RSVD)
                res.status = STAT_BAD_LEVEL;
            else
            begin
                case (it.op)
                    OP_ADD:
                    begin
                        if (it.level == LVL_APP)
                            q = int'(Q_APP);
                        else
                            q = 2 * int'(it.level) + ((it.frame_type == CRYPTO_TYPE) ? 1 : 0);
                        if (fill[q] >= DEPTH)
                            res.status = STAT_FULL;
                        else
                        begin
                            slots[q][tail[q]].handle = it.frame_handle;
                            slots[q][tail[q]].bytes  = it.frame_bytes;
                            tail[q] = (tail[q] + 1 >= DEPTH) ? 0 : tail[q] + 1;
                            fill[q]++;
                        end
                    end
                    OP_GET:
                    begin
                        if (it.level == LVL_APP)
                            void'(pop_fitting(int'(Q_APP), it.room, res));
                        else
                        begin
                            q = 2 * int'(it.level);
                            if (!pop_fitting(q + 1, it.room, res))
                                void'(pop_fitting(q, it.room, res));
                        end
                    end
                    default:
                    begin
                        if (it.level == LVL_APP)
                            res.status = STAT_BAD_LEVEL;
                        else
                        begin
                            q = 2 * int'(it.level);
                            empty_queue(q);
                            empty_queue(q + 1);
                        end
                    end
                endcase
            end
            owed_results.push_back(res);
        endfunction

        // compare one result item against the oldest owed result
        function void check_result(out_item_t act);
            out_item_t exp;
            if (owed_results.size() == 0)
            begin
                $error("result item arrived with none owed");
                errors++;
                return;
            end
            exp = owed_results.pop_front();
            if (act.got_frame !== exp.got_frame)
            begin
                $error("got_frame mismatch: expected %0d, actual %0d",
                       exp.got_frame, act.got_frame);
                errors++;
            end
            if (act.out_handle !== exp.out_handle)
            begin
                $error("out_handle mismatch: expected 0x%04h, actual 0x%04h",
                       exp.out_handle, act.out_handle);
                errors++;
            end
            if (act.out_bytes !== exp.out_bytes)
            begin
                $error("out_bytes mismatch: expected 0x%04h, actual 0x%04h",
                       exp.out_bytes, act.out_bytes);
                errors++;
            end
            if (act.status !== exp.status)
            begin
                $error("status mismatch: expected %0d, actual %0d",
                       exp.status, act.status);
                errors++;
            end
        endfunction

        function int owed_count();
            return owed_results.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    frame_queue_scoreboard #(QUEUE_DEPTH) sb;
    int unsigned cycle_count = 0;
    int          items_sent  = 0;
    bit          src_calm    = 1'b0;
    bit          sink_calm   = 1'b0;

    retransmit_frame_queue_bank #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // idle length: mostly short, a few long, none in calm stretches
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_bytes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'h0000;
        else if (r < 20)
            return 16'hffff;
        else if (r < 70)
            return 16'($urandom_range(0, 1500));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_room();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return 16'hffff;
        else if (r < 35)
            return 16'h0000;
        else if (r < 75)
            return 16'($urandom_range(0, 2000));
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] pick_type(bit crypto);
        logic [7:0] t;
        if (crypto)
            return CRYPTO_TYPE;
        t = 8'($urandom);
        if (t == CRYPTO_TYPE)
            t = 8'h07;
        return t;
    endfunction

    function automatic in_item_t make_item(op_t op, level_t lvl, logic [15:0] h,
                                           logic [7:0] t, logic [15:0] b,
                                           logic [15:0] room);
        in_item_t it;
        it.op           = op;
        it.level        = lvl;
        it.frame_handle = h;
        it.frame_type   = t;
        it.frame_bytes  = b;
        it.room         = room;
        return it;
    endfunction

    // drive one item; called and returns at a falling edge
    task automatic send_item(in_item_t it);
        int gap;
        s_axis_tdata  = IN_TDATA_W'(it);
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_accepted(it);
        if (it.op != OP_RSVD && it.level != LVL_RSVD)
            items_sent++;
        @(negedge clk);
        gap = pick_gap(src_calm);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_add(level_t lvl, logic [15:0] h, logic [7:0] t, logic [15:0] b);
        send_item(make_item(OP_ADD, lvl, h, t, b, 16'($urandom)));
    endtask

    task automatic send_get(level_t lvl, logic [15:0] room);
        send_item(make_item(OP_GET, lvl, 16'($urandom), 8'($urandom), 16'($urandom), room));
    endtask

    task automatic send_drop(level_t lvl);
        send_item(make_item(OP_DROP, lvl, 16'($urandom), 8'($urandom), 16'($urandom),
                            16'($urandom)));
    endtask

    // extremes, every op and the special cases
    task automatic run_directed();
        send_item(make_item(OP_RSVD, LVL_INIT, 16'h1234, CRYPTO_TYPE, 16'h10, 16'hffff));
        send_add(LVL_RSVD, 16'h0001, 8'h00, 16'h0001);
        send_get(LVL_RSVD, 16'hffff);
        send_drop(LVL_RSVD);
        send_get(LVL_INIT, 16'hffff);          // empty level
        send_drop(LVL_APP);                    // drop not allowed at app level
        send_add(LVL_INIT, 16'h0000, 8'h00, 16'h0000);
        send_add(LVL_INIT, 16'hffff, CRYPTO_TYPE, 16'hffff);
        send_add(LVL_HS, 16'h1111, 8'hff, 16'h0100);
        send_add(LVL_HS, 16'h2222, CRYPTO_TYPE, 16'h0200);
        send_add(LVL_APP, 16'h3333, CRYPTO_TYPE, 16'h1234);  // crypto type stays on app queue
        send_get(LVL_INIT, 16'h0000);          // crypto too big, plain fits
        send_get(LVL_INIT, 16'hfffe);          // crypto one byte too big, plain empty
        send_get(LVL_INIT, 16'hffff);          // crypto fits exactly
        send_get(LVL_HS, 16'h00ff);            // neither fits
        send_get(LVL_HS, 16'h0150);            // plain only
        send_get(LVL_HS, 16'h0200);            // crypto
        send_get(LVL_APP, 16'h1233);
        send_get(LVL_APP, 16'h1234);
        send_add(LVL_HS, 16'habcd, CRYPTO_TYPE, 16'h0005);
        send_add(LVL_INIT, 16'h5a5a, 8'h05, 16'h0007);
        send_drop(LVL_HS);
        send_get(LVL_HS, 16'hffff);
        send_drop(LVL_INIT);
        send_get(LVL_INIT, 16'hffff);
    endtask

    // one random phase of well-formed traffic or noise
    task automatic run_phase();
        int     kind;
        int     n;
        int     r;
        bit     crypto;
        level_t lvl;
        kind   = $urandom_range(0, 99);
        lvl    = level_t'($urandom_range(0, 2));
        crypto = 1'($urandom_range(0, 1));
        src_calm = ($urandom_range(0, 3) == 0);
        if (kind < 25)
        begin
            // fill one queue to overflow
            n = $urandom_range(14, 20);
            repeat (n)
                send_add(lvl, 16'($urandom), pick_type(crypto), pick_bytes());
        end
        else if (kind < 50)
        begin
            // gets at random levels
            n = $urandom_range(6, 20);
            repeat (n)
                send_get(level_t'($urandom_range(0, 2)), pick_room());
        end
        else if (kind < 80)
        begin
            // mixed traffic
            n = $urandom_range(10, 30);
            repeat (n)
            begin
                r   = $urandom_range(0, 99);
                lvl = level_t'($urandom_range(0, 2));
                if (r < 47)
                    send_add(lvl, 16'($urandom), pick_type($urandom_range(0, 2) == 0),
                             pick_bytes());
                else if (r < 94)
                    send_get(lvl, pick_room());
                else
                    send_drop(lvl);
            end
        end
        else if (kind < 90)
        begin
            // adds and drops mixed, about one drop in three
            n = $urandom_range(3, 8);
            repeat (n)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_drop(level_t'($urandom_range(0, 2)));
                else
                    send_add(level_t'($urandom_range(0, 2)), 16'($urandom),
                             pick_type($urandom_range(0, 1) == 1), pick_bytes());
            end
        end
        else
        begin
            // noise: any op, any level
            n = $urandom_range(5, 12);
            repeat (n)
                send_item(make_item(op_t'($urandom_range(0, 3)),
                                    level_t'($urandom_range(0, 3)),
                                    16'($urandom), 8'($urandom), pick_bytes(), pick_room()));
        end
    endtask

    // result sink: random stalls on the master side
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            sink_calm = ($urandom_range(0, 4) == 0);
            stall = pick_gap(sink_calm);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    end

    // check each accepted result item
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(out_item_t'(m_axis_tdata[OUT_W-1:0]));
    end

    // stimulus and end of run
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        sb = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        src_calm = 1'($urandom_range(0, 1));
        run_directed();
        while (items_sent < ITEM_TARGET)
            run_phase();
        s_axis_tvalid = 1'b0;
        while (sb.owed_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
